/* sv/affine_point_transform_macros.svh */
// Assertion macros shared by the affine point transform RTL.
`ifndef AFFINE_POINT_TRANSFORM_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("affine_point_transform: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define APT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("affine_point_transform: assertion failed");

`endif

/* sv/apt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the affine point transform.
package apt_pkg;

  localparam int APT_W         = 32;
  localparam int APT_FRAC_BITS = 16;
  localparam int APT_DIM       = 4;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_XFORM = 2'd2
  } apt_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } apt_state_t;

  localparam logic [1:0] LAST_ROW = 2'd2;

  // One matrix row, column 0 in element 0.
  typedef logic [APT_DIM-1:0][APT_W-1:0] apt_row_t;
  // Point coordinates, x in element 0.
  typedef logic [2:0][APT_W-1:0] apt_pt_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] row;
  } apt_tag_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [1:0]              row;
    logic [1:0]              col;
    logic signed [APT_W-1:0] entry_value;
    logic signed [APT_W-1:0] in_x;
    logic signed [APT_W-1:0] in_y;
    logic signed [APT_W-1:0] in_z;
  } apt_in_t;

  typedef struct packed {
    logic signed [APT_W-1:0] out_x;
    logic signed [APT_W-1:0] out_y;
    logic signed [APT_W-1:0] out_z;
    logic signed [APT_W-1:0] read_data;
    logic                    is_point;
  } apt_out_t;

endpackage

/* sv/apt_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one payload per transaction.
interface apt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/affine_point_transform.sv */
`timescale 1ns / 1ps
// Top level: 4x4 fixed-point matrix store with entry access and point transform.
//
//   channel  dir  handshake              payload
//   in_ch    in   valid/ready            req_type, row, col, entry_value, in_x/y/z
//   out_ch   out  valid/ready            out_x/y/z, read_data, is_point
//
// A write leaves the sequencer idle; a read and a transform hold off the next accept
// until their result is done: the matrix memory gives one row per cycle (rows 0..2),
// and each row then runs through the 3-stage multiply-accumulate pipe.
// After reset the matrix reads as identity at once (per-entry valid flags).
// A finished result waits in the output register; a new transaction is taken
// only while that register is empty or being emptied in the same cycle.
`include "affine_point_transform_macros.svh"
module affine_point_transform #(
  parameter int FRAC_BITS = apt_pkg::APT_FRAC_BITS
) (
  input logic        clk,
  input logic        rst_n,
  apt_stream_if.sink   in_ch,
  apt_stream_if.source out_ch
);

  localparam logic [apt_pkg::APT_W-1:0] ONE_Q = apt_pkg::APT_W'(64'd1 << FRAC_BITS);

  apt_pkg::apt_state_t state_r, state_nxt;
  logic [1:0] iss_row_r, iss_row_nxt;
  logic       in_ready, in_acc, req_wr, req_rd, req_xf;
  logic       rd_en, rd_pt;
  logic [1:0] rd_addr;
  logic       done;

  apt_pkg::apt_row_t mat_mem [apt_pkg::APT_DIM];
  logic [apt_pkg::APT_DIM-1:0][apt_pkg::APT_DIM-1:0] ent_vld_r;

  apt_pkg::apt_row_t rd_q;
  logic [apt_pkg::APT_DIM-1:0] rd_vld_q;
  logic       rd_v_r, rd_pt_r;
  logic [1:0] rd_row_r, rd_col_r;
  apt_pkg::apt_row_t row_eff;

  apt_pkg::apt_pt_t  pt_r;
  apt_pkg::apt_tag_t mac_tag_in, mac_tag_out;
  logic signed [apt_pkg::APT_W-1:0] mac_res;

  logic              out_valid_r;
  apt_pkg::apt_out_t out_pl_r;

  assign req_wr = (in_ch.payload.req_type == apt_pkg::REQ_WRITE);
  assign req_rd = (in_ch.payload.req_type == apt_pkg::REQ_READ);
  assign req_xf = (in_ch.payload.req_type == apt_pkg::REQ_XFORM);
  assign in_ch.ready = in_ready;
  assign in_acc = in_ch.valid && in_ready;

  assign done = (rd_v_r && !rd_pt_r) ||
                (mac_tag_out.vld && (mac_tag_out.row == apt_pkg::LAST_ROW));

  // Next state
  always_comb begin
    state_nxt   = state_r;
    iss_row_nxt = iss_row_r;
    unique case (state_r)
      apt_pkg::ST_IDLE: begin
        if (in_acc && req_xf) begin
          state_nxt   = apt_pkg::ST_ISSUE;
          iss_row_nxt = 2'd1;
        end else if (in_acc && req_rd) begin
          state_nxt = apt_pkg::ST_WAIT;
        end
      end
      apt_pkg::ST_ISSUE: begin
        iss_row_nxt = iss_row_r + 2'd1;
        if (iss_row_r == apt_pkg::LAST_ROW) begin
          state_nxt = apt_pkg::ST_WAIT;
        end
      end
      apt_pkg::ST_WAIT: begin
        if (done) begin
          state_nxt = apt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = apt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_pt    = 1'b0;
    rd_addr  = in_ch.payload.row;
    unique case (state_r)
      apt_pkg::ST_IDLE: begin
        in_ready = !out_valid_r || out_ch.ready;
        rd_en    = in_ch.valid && in_ready && (req_rd || req_xf);
        rd_pt    = req_xf;
        // a transform starts at row 0
        if (req_xf) begin
          rd_addr = 2'd0;
        end
      end
      apt_pkg::ST_ISSUE: begin
        rd_en   = 1'b1;
        rd_pt   = 1'b1;
        rd_addr = iss_row_r;
      end
      apt_pkg::ST_WAIT: begin
        rd_en = 1'b0;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= apt_pkg::ST_IDLE;
      iss_row_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      iss_row_r <= iss_row_nxt;
    end
  end

  // Matrix memory: one entry written, one row read per cycle. The sequencer
  // takes no write while a read is in flight, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (in_acc && req_wr) begin
      mat_mem[in_ch.payload.row][in_ch.payload.col] <= in_ch.payload.entry_value;
    end
    if (rd_en) begin
      rd_q     <= mat_mem[rd_addr];
      rd_vld_q <= ent_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (in_acc && req_wr) begin
      ent_vld_r[in_ch.payload.row][in_ch.payload.col] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pt_r  <= rd_pt;
      rd_row_r <= rd_addr;
      rd_col_r <= in_ch.payload.col;
    end
    if (in_acc && req_xf) begin
      pt_r[0] <= in_ch.payload.in_x;
      pt_r[1] <= in_ch.payload.in_y;
      pt_r[2] <= in_ch.payload.in_z;
    end
  end

  // Entries never written read as identity.
  always_comb begin
    for (int c = 0; c < apt_pkg::APT_DIM; c++) begin
      if (rd_vld_q[2'(c)]) begin
        row_eff[2'(c)] = rd_q[2'(c)];
      end else if (rd_row_r == 2'(c)) begin
        row_eff[2'(c)] = ONE_Q;
      end else begin
        row_eff[2'(c)] = '0;
      end
    end
  end

  assign mac_tag_in.vld = rd_v_r && rd_pt_r;
  assign mac_tag_in.row = rd_row_r;

  apt_row_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (mac_tag_in),
    .row_i (row_eff),
    .pt_i  (pt_r),
    .tag_o (mac_tag_out),
    .res_o (mac_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r && !rd_pt_r) begin
      out_pl_r.out_x     <= '0;
      out_pl_r.out_y     <= '0;
      out_pl_r.out_z     <= '0;
      out_pl_r.read_data <= row_eff[rd_col_r];
      out_pl_r.is_point  <= 1'b0;
    end else if (mac_tag_out.vld) begin
      unique case (mac_tag_out.row)
        2'd0:    out_pl_r.out_x <= mac_res;
        2'd1:    out_pl_r.out_y <= mac_res;
        2'd2:    out_pl_r.out_z <= mac_res;
        default: out_pl_r.out_z <= out_pl_r.out_z;
      endcase
      out_pl_r.read_data <= '0;
      out_pl_r.is_point  <= 1'b1;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_pl_r;

  `APT_ASSERT_NOW(a_result_slot_free, done, !out_valid_r)
  `APT_ASSERT_NEXT(a_write_stays_idle, in_acc && req_wr, state_r == apt_pkg::ST_IDLE)
  `APT_ASSERT_NOW(a_read_result, in_acc && req_rd, ##2 (out_valid_r && !out_pl_r.is_point))
  `APT_ASSERT_NOW(a_point_result, in_acc && req_xf, ##7 (out_valid_r && out_pl_r.is_point))

endmodule

/* sv/apt_row_mac.sv */
`timescale 1ns / 1ps
// Three-stage row multiply-accumulate: products, sum, shift/offset/saturate.
module apt_row_mac #(
  parameter int FRAC_BITS = apt_pkg::APT_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  apt_pkg::apt_tag_t            tag_i,
  input  apt_pkg::apt_row_t            row_i,
  input  apt_pkg::apt_pt_t             pt_i,
  output apt_pkg::apt_tag_t            tag_o,
  output logic signed [apt_pkg::APT_W-1:0] res_o
);

  localparam int PW = 2 * apt_pkg::APT_W;  // product width
  localparam int SW = PW + 2;              // sum of three products
  localparam int TW = SW + 1;              // sum plus offset column
  localparam logic signed [TW-1:0] SAT_MAX = TW'((64'sd1 <<< (apt_pkg::APT_W - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_MIN = ~SAT_MAX;

  apt_pkg::apt_tag_t tag_a_r, tag_b_r, tag_c_r;
  logic signed [PW-1:0] prod_r [3];
  logic signed [apt_pkg::APT_W-1:0] m3_a_r, m3_b_r;
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] shifted;
  logic signed [TW-1:0] total;
  logic signed [apt_pkg::APT_W-1:0] sat_nxt, res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_c_r <= '0;
    end else begin
      tag_a_r <= tag_i;
      tag_b_r <= tag_a_r;
      tag_c_r <= tag_b_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[2'(c)] <= PW'($signed(row_i[2'(c)])) * PW'($signed(pt_i[2'(c)]));
    end
    m3_a_r <= $signed(row_i[apt_pkg::APT_DIM-1]);
    sum_r  <= SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]);
    m3_b_r <= m3_a_r;
    res_r  <= sat_nxt;
  end

  // Floor shift, then add the w column, which is already in output scale.
  always_comb begin
    shifted = sum_r >>> FRAC_BITS;
    total   = TW'(shifted) + TW'(m3_b_r);
    priority if (total > SAT_MAX) begin
      sat_nxt = SAT_MAX[apt_pkg::APT_W-1:0];
    end else if (total < SAT_MIN) begin
      sat_nxt = SAT_MIN[apt_pkg::APT_W-1:0];
    end else begin
      sat_nxt = total[apt_pkg::APT_W-1:0];
    end
  end

  assign tag_o = tag_c_r;
  assign res_o = res_r;

endmodule
